// File: rtl/core/bark_band_energy_accumulator_unit_macros.svh
// Assertion macros shared by the checker of the Bark band energy accumulator.
// Depends on a clock named clock and a synchronous active-high reset named reset.
`ifndef BARK_BAND_ENERGY_ACCUMULATOR_UNIT_MACROS_SVH
`define BARK_BAND_ENERGY_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define BBEA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define BBEA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs through reset
`define BBEA_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/bbea_pkg.sv
// Shared types and fixed field widths of the Bark band energy accumulator.
// No dependencies; used by every module of the block except bbea_fifo.
`timescale 1ns / 1ps

package bbea_pkg;

   // Fixed field widths
   localparam int BAND_IDX_W = 5;
   localparam int BIN_IDX_W  = 10;
   localparam int WEIGHT_W   = 17;
   localparam int POWER_W    = 32;
   localparam int ENERGY_W   = 32;
   localparam int CSR_W      = 11;
   localparam int STEP_W     = 5;

   localparam logic [CSR_W-1:0] BIN_COUNT_RESET = 11'd513;

   // Operation codes of an input word
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_BIN  = 1'b1
   } op_type;

   // Word passed from front to back
   typedef struct packed {
      op_type                  op;
      logic [BAND_IDX_W-1:0]   weight_band;
      logic [BIN_IDX_W-1:0]    weight_bin;
      logic [WEIGHT_W-1:0]     weight_value;
      logic [POWER_W-1:0]      bin_power;
   } work_item_type;

   // Result word
   typedef struct packed {
      logic [BAND_IDX_W-1:0]   band_index;
      logic [ENERGY_W-1:0]     band_energy;
      logic                    last_band;
   } result_type;

endpackage

// File: rtl/core/bbea_fifo.sv
// Small register FIFO used for the work queue and the result queue.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module bbea_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/bbea_front.sv
// Front end: takes input words, classifies them and drops out-of-range loads.
// Depends on bbea_pkg; feeds the work queue.
`timescale 1ns / 1ps

module bbea_front #(
   parameter int NUM_BANDS = 24,
   parameter int MAX_BINS  = 1024
) (
   input  logic                               push,
   output logic                               full,
   input  logic                               req_operation,
   input  logic [bbea_pkg::BAND_IDX_W-1:0]    req_weight_band,
   input  logic [bbea_pkg::BIN_IDX_W-1:0]     req_weight_bin,
   input  logic [bbea_pkg::WEIGHT_W-1:0]      req_weight_value,
   input  logic [bbea_pkg::POWER_W-1:0]       req_bin_power,
   input  logic                               wq_full,
   output logic                               wq_push,
   output bbea_pkg::work_item_type            wq_data
);

   bbea_pkg::op_type op;
   logic             load_in_range;
   logic             keep;

   assign op = bbea_pkg::op_type'(req_operation);

   // A load outside the weight table is accepted and then dropped
   assign load_in_range = (32'(req_weight_band) < NUM_BANDS) &&
                          (32'(req_weight_bin) < MAX_BINS);
   assign keep = (op == bbea_pkg::OP_BIN) || load_in_range;

   assign full    = wq_full;
   assign wq_push = push && !wq_full && keep;

   // Pack the queue word
   always_comb begin
      wq_data.op           = op;
      wq_data.weight_band  = req_weight_band;
      wq_data.weight_bin   = req_weight_bin;
      wq_data.weight_value = req_weight_value;
      wq_data.bin_power    = req_bin_power;
   end

endmodule

// File: rtl/core/bbea_divider.sv
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on bbea_pkg; the caller guarantees the quotient fits in 32 bits.
`timescale 1ns / 1ps

module bbea_divider #(
   parameter int DIVISOR_W = 27
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [DIVISOR_W+bbea_pkg::ENERGY_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]                      divisor,
   output logic                                      busy,
   output logic [bbea_pkg::ENERGY_W-1:0]             quotient
);

   localparam int QUO_W = bbea_pkg::ENERGY_W;

   logic                          busy_ff;
   logic [bbea_pkg::STEP_W-1:0]   step_ff;
   logic [DIVISOR_W-1:0]          rem_ff;
   logic [DIVISOR_W-1:0]          div_ff;
   logic [QUO_W-1:0]              quo_ff;
   logic                          zero_ff;
   logic [DIVISOR_W:0]            shifted;
   logic [DIVISOR_W:0]            diff;
   logic                          fits;

   // One trial subtraction per cycle
   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = !diff[DIVISOR_W];

   assign busy     = busy_ff;
   assign quotient = zero_ff ? '0 : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= bbea_pkg::STEP_W'(QUO_W - 1);
      end else if (busy_ff) begin
         busy_ff <= (step_ff != '0);
         step_ff <= step_ff - bbea_pkg::STEP_W'(1);
      end
   end

   // Remainder starts with the upper dividend bits, which stay below the divisor
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend[DIVISOR_W+QUO_W-1:QUO_W];
         quo_ff  <= dividend[QUO_W-1:0];
         div_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

endmodule

// File: rtl/core/bbea_back.sv
// Back end: weight memory, per-band multiply-accumulate and frame-end divides.
// Depends on bbea_pkg and bbea_divider; drains the work queue, fills the result queue.
`timescale 1ns / 1ps

module bbea_back #(
   parameter int NUM_BANDS = 24,
   parameter int MAX_BINS  = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [bbea_pkg::CSR_W-1:0]      csr_wr_data,
   input  bbea_pkg::work_item_type         wq_data,
   input  logic                            wq_empty,
   output logic                            wq_pop,
   output bbea_pkg::result_type            rq_data,
   input  logic                            rq_full,
   output logic                            rq_push
);

   localparam int BAND_W     = $clog2(NUM_BANDS);
   localparam int BIN_W      = $clog2(MAX_BINS);
   localparam int CNT_W      = $clog2(MAX_BINS + 1);
   localparam int BIN_XW     = (BIN_W > bbea_pkg::BIN_IDX_W) ? BIN_W : bbea_pkg::BIN_IDX_W;
   localparam int ADDR_W     = BAND_W + BIN_W;
   localparam int WMEM_DEPTH = NUM_BANDS * (2 ** BIN_W);
   localparam int NORM_W     = bbea_pkg::WEIGHT_W + BIN_W;
   localparam int SUM_W      = NORM_W + bbea_pkg::ENERGY_W;
   localparam int PROD_W     = bbea_pkg::POWER_W + bbea_pkg::WEIGHT_W;
   localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_DIV_START,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [BIN_W-1:0]                pos_ff, pos_in;
   logic [BAND_W-1:0]               issue_band_ff, issue_band_in;
   logic [BAND_W-1:0]               div_band_ff, div_band_in;
   logic [bbea_pkg::POWER_W-1:0]    power_ff, power_in;
   logic [bbea_pkg::CSR_W-1:0]      bin_count_ff, bin_count_in;

   logic [CNT_W-1:0]                eff_count;
   logic [CNT_W-1:0]                pos_plus;
   logic                            frame_end;

   logic                            mem_we, rd_en, div_start, clear_en;
   logic [BIN_XW-1:0]               ld_bin_ext;
   logic [ADDR_W-1:0]               wr_addr, rd_addr;
   logic [bbea_pkg::WEIGHT_W-1:0]   wmem [WMEM_DEPTH];
   logic [bbea_pkg::WEIGHT_W-1:0]   rdata_ff;

   logic                            s1_valid_ff, s2_valid_ff;
   logic [BAND_W-1:0]               s1_band_ff, s2_band_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic [bbea_pkg::WEIGHT_W-1:0]   w2_ff;

   logic [SUM_W-1:0]                acc_ff  [NUM_BANDS];
   logic [NORM_W-1:0]               norm_ff [NUM_BANDS];
   logic [BAND_W-1:0]               acc_idx;
   logic [SUM_W-1:0]                acc_rd;
   logic [NORM_W-1:0]               norm_rd;

   logic                            div_busy;
   logic [bbea_pkg::ENERGY_W-1:0]   div_quotient;

   // Bin count clamped to 1..MAX_BINS
   always_comb begin
      if (bin_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(bin_count_ff) > MAX_BINS) begin
         eff_count = CNT_W'(MAX_BINS);
      end else begin
         eff_count = CNT_W'(bin_count_ff);
      end
   end

   assign pos_plus  = CNT_W'(pos_ff) + CNT_W'(1);
   assign frame_end = (pos_plus >= eff_count);

   // Sequencer: loads, band sweep per bin, then one divide per band at frame end
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      issue_band_in = issue_band_ff;
      div_band_in   = div_band_ff;
      power_in      = power_ff;
      bin_count_in  = csr_wr_en ? csr_wr_data : bin_count_ff;
      wq_pop        = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      div_start     = 1'b0;
      rq_push       = 1'b0;
      clear_en      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!wq_empty) begin
               wq_pop = 1'b1;
               if (wq_data.op == bbea_pkg::OP_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  power_in      = wq_data.bin_power;
                  issue_band_in = '0;
                  state_in      = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            rd_en = 1'b1;
            if (issue_band_ff == LAST_BAND) begin
               if (frame_end) begin
                  pos_in   = '0;
                  state_in = S_DRAIN;
               end else begin
                  pos_in   = pos_plus[BIN_W-1:0];
                  state_in = S_IDLE;
               end
            end else begin
               issue_band_in = issue_band_ff + BAND_W'(1);
            end
         end
         S_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               div_band_in = '0;
               state_in    = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rq_full) begin
               rq_push  = 1'b1;
               clear_en = 1'b1;
               if (div_band_ff == LAST_BAND) begin
                  state_in = S_IDLE;
               end else begin
                  div_band_in = div_band_ff + BAND_W'(1);
                  state_in    = S_DIV_START;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         issue_band_ff <= '0;
         div_band_ff   <= '0;
         power_ff      <= '0;
         bin_count_ff  <= bbea_pkg::BIN_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         issue_band_ff <= issue_band_in;
         div_band_ff   <= div_band_in;
         power_ff      <= power_in;
         bin_count_ff  <= bin_count_in;
      end
   end

   // Weight memory: row per band, column per bin
   assign ld_bin_ext = BIN_XW'(wq_data.weight_bin);
   assign wr_addr    = {wq_data.weight_band[BAND_W-1:0], ld_bin_ext[BIN_W-1:0]};
   assign rd_addr    = {issue_band_ff, pos_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wmem[wr_addr] <= wq_data.weight_value;
      end
      if (rd_en) begin
         rdata_ff <= wmem[rd_addr];
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_band_ff <= issue_band_ff;
      s2_band_ff <= s1_band_ff;
      prod_ff    <= PROD_W'(power_ff) * PROD_W'(rdata_ff);
      w2_ff      <= rdata_ff;
   end

   // Accumulators, one read port shared by accumulate and divide
   assign acc_idx = s2_valid_ff ? s2_band_ff : div_band_ff;
   assign acc_rd  = acc_ff[acc_idx];
   assign norm_rd = norm_ff[acc_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANDS; i++) begin
            acc_ff[i]  <= '0;
            norm_ff[i] <= '0;
         end
      end else if (s2_valid_ff) begin
         acc_ff[s2_band_ff]  <= acc_rd + SUM_W'(prod_ff);
         norm_ff[s2_band_ff] <= norm_rd + NORM_W'(w2_ff);
      end else if (clear_en) begin
         acc_ff[div_band_ff]  <= '0;
         norm_ff[div_band_ff] <= '0;
      end
   end

   // Normalizing divide
   bbea_divider #(
      .DIVISOR_W (NORM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_rd),
      .divisor  (norm_rd),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // Result word
   always_comb begin
      rq_data.band_index  = bbea_pkg::BAND_IDX_W'(div_band_ff);
      rq_data.band_energy = div_quotient;
      rq_data.last_band   = (div_band_ff == LAST_BAND);
   end

endmodule

// File: rtl/core/bark_band_energy_accumulator_unit.sv
// Bark band energy accumulator. A weight load is one weight-memory write in the back end; a
// spectrum bin takes one weight-memory read per band (a single read port serves all bands).
// At frame end the multiply pipeline drains, then the 32-step divider runs once per band,
// with one result word pushed per band. Words queue in two-entry FIFOs on both sides.
// Reset (synchronous, active high) clears queues, accumulators and bin position and
// sets bin_count to 513; the weight memory is not cleared and must be loaded first.
`timescale 1ns / 1ps

module bark_band_energy_accumulator_unit #(
   parameter int NUM_BANDS = 24,
   parameter int MAX_BINS  = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_operation,
   input  logic [bbea_pkg::BAND_IDX_W-1:0]    req_weight_band,
   input  logic [bbea_pkg::BIN_IDX_W-1:0]     req_weight_bin,
   input  logic [bbea_pkg::WEIGHT_W-1:0]      req_weight_value,
   input  logic [bbea_pkg::POWER_W-1:0]       req_bin_power,
   output logic                               empty,
   input  logic                               pop,
   output logic [bbea_pkg::BAND_IDX_W-1:0]    rsp_band_index,
   output logic [bbea_pkg::ENERGY_W-1:0]      rsp_band_energy,
   output logic                               rsp_last_band,
   input  logic                               csr_wr_en,
   input  logic [bbea_pkg::CSR_W-1:0]         csr_wr_data
);

   localparam int WQ_DEPTH = 2;
   localparam int RQ_DEPTH = 2;

   logic                      wq_push, wq_full, wq_pop, wq_empty;
   bbea_pkg::work_item_type   wq_in, wq_head;
   logic                      rq_push, rq_full;
   bbea_pkg::result_type      rq_in, rq_head;

   // Classify incoming words
   bbea_front #(
      .NUM_BANDS (NUM_BANDS),
      .MAX_BINS  (MAX_BINS)
   ) u_front (
      .push             (push),
      .full             (full),
      .req_operation    (req_operation),
      .req_weight_band  (req_weight_band),
      .req_weight_bin   (req_weight_bin),
      .req_weight_value (req_weight_value),
      .req_bin_power    (req_bin_power),
      .wq_full          (wq_full),
      .wq_push          (wq_push),
      .wq_data          (wq_in)
   );

   // Work queue between front and back
   bbea_fifo #(
      .WIDTH ($bits(bbea_pkg::work_item_type)),
      .DEPTH (WQ_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (wq_push),
      .push_data (wq_in),
      .full      (wq_full),
      .pop       (wq_pop),
      .pop_data  (wq_head),
      .empty     (wq_empty)
   );

   // Accumulate and normalize
   bbea_back #(
      .NUM_BANDS (NUM_BANDS),
      .MAX_BINS  (MAX_BINS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .wq_data     (wq_head),
      .wq_empty    (wq_empty),
      .wq_pop      (wq_pop),
      .rq_data     (rq_in),
      .rq_full     (rq_full),
      .rq_push     (rq_push)
   );

   // Result queue
   bbea_fifo #(
      .WIDTH ($bits(bbea_pkg::result_type)),
      .DEPTH (RQ_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .full      (rq_full),
      .pop       (pop),
      .pop_data  (rq_head),
      .empty     (empty)
   );

   assign rsp_band_index  = rq_head.band_index;
   assign rsp_band_energy = rq_head.band_energy;
   assign rsp_last_band   = rq_head.last_band;

endmodule

// File: rtl/core/bbea_checker.sv
// Port-level checker for the Bark band energy accumulator, bound to the top level.
// Depends on bbea_pkg and bark_band_energy_accumulator_unit_macros.svh.
`timescale 1ns / 1ps
`include "bark_band_energy_accumulator_unit_macros.svh"

module bbea_checker #(
   parameter int NUM_BANDS = 24
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               push,
   input logic                               full,
   input logic                               empty,
   input logic                               pop,
   input logic [bbea_pkg::BAND_IDX_W-1:0]    rsp_band_index,
   input logic [bbea_pkg::ENERGY_W-1:0]      rsp_band_energy,
   input logic                               rsp_last_band
);

   localparam logic [bbea_pkg::BAND_IDX_W-1:0] LAST_IDX =
      bbea_pkg::BAND_IDX_W'(NUM_BANDS - 1);

   logic [bbea_pkg::BAND_IDX_W-1:0] expect_band_ff;
   logic                            push_seen_ff;

   // Band number the next result word must carry
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_band_ff <= '0;
         push_seen_ff   <= 1'b0;
      end else begin
         push_seen_ff <= push_seen_ff || (push && !full);
         if (pop && !empty) begin
            expect_band_ff <= rsp_last_band ? '0 :
                              expect_band_ff + bbea_pkg::BAND_IDX_W'(1);
         end
      end
   end

   `BBEA_ASSERT_ALWAYS_NEXT(a_reset_clears, reset, empty && !full, "queues not clear after reset")

   `BBEA_ASSERT_NOW(a_no_result_before_input, !push_seen_ff, empty, "result word with no input")

   `BBEA_ASSERT_NOW(a_band_order, !empty, rsp_band_index == expect_band_ff, "band out of order")

   `BBEA_ASSERT_NOW(a_last_flag, !empty, rsp_last_band == (rsp_band_index == LAST_IDX), "bad last flag")

   `BBEA_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_band_index) && $stable(rsp_band_energy) && $stable(rsp_last_band), "result word changed while stalled")

endmodule

bind bark_band_energy_accumulator_unit bbea_checker #(
   .NUM_BANDS (NUM_BANDS)
) u_bbea_checker (
   .clock           (clock),
   .reset           (reset),
   .push            (push),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_band_index  (rsp_band_index),
   .rsp_band_energy (rsp_band_energy),
   .rsp_last_band   (rsp_last_band)
);
